// File: hdl/mnp_pkg.sv
// mnp_pkg: shared types, codes and constants of the midi note pairing unit
// no dependencies; imported by the datapath, controller and top level
`timescale 1ns / 1ps

package mnp_pkg;

    localparam int SLOT_W   = 11;
    localparam int SLOT_NUM = 2048;
    localparam int CMD_W    = 2;
    localparam int CH_W     = 4;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int TICK_P_W = 32;
    localparam int TPQ_W    = 15;

    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd2;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    localparam logic [VEL_W-1:0] RELEASE_DEFAULT = 7'd64;
    localparam logic [TPQ_W-1:0] TPQ_RESET       = 15'd480;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CH_W-1:0]     channel;
        logic [NOTE_W-1:0]   note_number;
        logic [VEL_W-1:0]    velocity;
        logic [TICK_P_W-1:0] event_tick;
    } t_evt;

    typedef struct packed {
        logic                kind;
        logic [TICK_P_W-1:0] start_tick;
        logic [TICK_P_W-1:0] end_tick;
        logic [CH_W-1:0]     out_channel;
        logic [NOTE_W-1:0]   out_note;
        logic [VEL_W-1:0]    on_velocity;
        logic [VEL_W-1:0]    release_velocity;
        logic                last;
    } t_note;

    // controller to datapath
    typedef struct packed {
        logic cap_item;
        logic clear_wr;
        logic push_wr;
        logic drop_load;
        logic pend_rd;
        logic pop_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_push;
        logic is_pop;
        logic is_flush;
        logic slot_empty;
        logic slot_full;
        logic last_pop;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/mnp_ifs.sv
// mnp_evt_if and mnp_note_if: valid/ready channels of the note pairing unit
// no dependencies
`timescale 1ns / 1ps

interface mnp_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  channel;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [31:0] event_tick;

    modport source (output valid, command, channel, note_number, velocity, event_tick,
                    input ready);
    modport sink   (input valid, command, channel, note_number, velocity, event_tick,
                    output ready);
endinterface

interface mnp_note_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] start_tick;
    logic [31:0] end_tick;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  on_velocity;
    logic [6:0]  release_velocity;
    logic        last;

    modport source (output valid, kind, start_tick, end_tick, out_channel, out_note,
                    on_velocity, release_velocity, last, input ready);
    modport sink   (input valid, kind, start_tick, end_tick, out_channel, out_note,
                    on_velocity, release_velocity, last, output ready);
endinterface

// File: hdl/midi_note_on_off_pairing_unit.sv
// midi_note_on_off_pairing_unit: top level of the midi note on/off pairing block
// depends on mnp_pkg, mnp_ifs (mnp_evt_if, mnp_note_if), mnp_ctrl and mnp_dp
`timescale 1ns / 1ps

// pairs note-on and note-off words into completed notes, one fifo of pending starts for each
// of the 2048 channel/note slots. after reset the block runs a clearing pass over the slot
// state memory with i_evt.ready low; ticks_per_quarter can be written during that time. a
// word is taken in idle, and the slot's count and head are read from the single-port slot
// memory as it is taken; in the next state a note-on writes back. a note-off or a zero-velocity
// note-on adds a registered read of the pending start memory and then the load of the output
// register. a flush overlaps the pending start reads, one orphan per cycle while the output
// register is free. pops and drops wait while the output register is still full. the output
// register holds the last result while the block goes back to idle and takes the next word.

module midi_note_on_off_pairing_unit
    import mnp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4,
    parameter int TICK_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TPQ_W-1:0] i_cfg_wr_data,
    mnp_evt_if.sink          i_evt,
    mnp_note_if.source       o_note
);

    t_evt       evt;
    t_note      note;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_sts;

    // incoming word as one struct for the datapath
    assign evt.command     = i_evt.command;
    assign evt.channel     = i_evt.channel;
    assign evt.note_number = i_evt.note_number;
    assign evt.velocity    = i_evt.velocity;
    assign evt.event_tick  = i_evt.event_tick;

    // sequencer: clear pass, then one word at a time
    mnp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (i_evt.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // slot memories, flush end arithmetic and output register
    mnp_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_evt         (evt),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_note        (note),
        .o_note_valid  (o_note.valid),
        .i_note_ready  (o_note.ready)
    );

    // result word onto the output channel
    assign o_note.kind             = note.kind;
    assign o_note.start_tick       = note.start_tick;
    assign o_note.end_tick         = note.end_tick;
    assign o_note.out_channel      = note.out_channel;
    assign o_note.out_note         = note.out_note;
    assign o_note.on_velocity      = note.on_velocity;
    assign o_note.release_velocity = note.release_velocity;
    assign o_note.last             = note.last;

endmodule

// File: hdl/mnp_dp.sv
// mnp_dp: slot state memory, pending start memory, flush end arithmetic, output register
// depends on mnp_pkg
`timescale 1ns / 1ps

module mnp_dp
    import mnp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4,
    parameter int TICK_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TPQ_W-1:0] i_cfg_wr_data,
    input  t_evt             i_evt,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_sts,
    output t_note            o_note,
    output logic             o_note_valid,
    input  logic             i_note_ready
);

    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int HEAD_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int SUM_W      = CNT_W + 1;
    localparam int SLOT_D_W   = CNT_W + HEAD_W;
    localparam int PEND_DEPTH = SLOT_NUM * FIFO_DEPTH;
    localparam int PEND_AW    = $clog2(PEND_DEPTH);
    localparam int PEND_W     = TICK_WIDTH + VEL_W;

    // captured word
    logic [CMD_W-1:0]      r_cmd;
    logic [CH_W-1:0]       r_ch;
    logic [NOTE_W-1:0]     r_note;
    logic [VEL_W-1:0]      r_vel;
    logic [TICK_WIDTH-1:0] r_tick;
    logic [TPQ_W-1:0]      r_tpq;
    logic [SLOT_W-1:0]     r_clr_addr;

    logic [SLOT_D_W-1:0] slot_mem [SLOT_NUM];
    logic [SLOT_D_W-1:0] r_slot_q;
    logic [PEND_W-1:0]   pend_mem [PEND_DEPTH];
    logic [PEND_W-1:0]   r_pend_q;

    t_note r_out;
    logic  r_out_valid;

    logic [CNT_W-1:0]      cnt;
    logic [HEAD_W-1:0]     head;
    logic [HEAD_W:0]       head_inc;
    logic [HEAD_W-1:0]     head_nxt;
    logic [SUM_W-1:0]      wp_sum;
    logic [HEAD_W-1:0]     wp;
    logic [SLOT_W-1:0]     slot_cur;
    logic [SLOT_W-1:0]     slot_in;
    logic [PEND_AW-1:0]    pend_base;
    logic [PEND_AW-1:0]    pend_waddr;
    logic [PEND_AW-1:0]    pend_raddr;
    logic [TICK_WIDTH-1:0] pend_tick;
    logic [VEL_W-1:0]      pend_vel;
    logic [TICK_WIDTH:0]   end_sum;
    logic [TICK_WIDTH-1:0] end_sat;
    logic [TICK_WIDTH-1:0] flush_end;
    logic                  is_flush;

    assign cnt      = r_slot_q[SLOT_D_W-1:HEAD_W];
    assign head     = r_slot_q[HEAD_W-1:0];
    assign head_inc = (HEAD_W + 1)'(head) + (HEAD_W + 1)'(1);
    assign head_nxt = (head_inc >= (HEAD_W + 1)'(FIFO_DEPTH)) ? '0 : head_inc[HEAD_W-1:0];

    // write position wraps at the fifo depth
    assign wp_sum = SUM_W'(head) + SUM_W'(cnt);
    assign wp     = (wp_sum >= SUM_W'(FIFO_DEPTH)) ? HEAD_W'(wp_sum - SUM_W'(FIFO_DEPTH))
                                                   : HEAD_W'(wp_sum);

    assign slot_cur   = {r_ch, r_note};
    assign slot_in    = {i_evt.channel, i_evt.note_number};
    assign pend_base  = PEND_AW'(slot_cur) * PEND_AW'(FIFO_DEPTH);
    assign pend_waddr = pend_base + PEND_AW'(wp);
    // during a flush the next read is issued alongside the current pop
    assign pend_raddr = pend_base + PEND_AW'(i_cmd.pop_load ? head_nxt : head);

    assign pend_tick = r_pend_q[PEND_W-1:VEL_W];
    assign pend_vel  = r_pend_q[VEL_W-1:0];

    // orphan end: max(track end, start + tpq/4), saturated
    assign end_sum   = (TICK_WIDTH + 1)'(pend_tick) + (TICK_WIDTH + 1)'(r_tpq[TPQ_W-1:2]);
    assign end_sat   = end_sum[TICK_WIDTH] ? '1 : end_sum[TICK_WIDTH-1:0];
    assign flush_end = (r_tick > end_sat) ? r_tick : end_sat;

    assign is_flush = (r_cmd == CMD_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq <= TPQ_RESET;
        end else if (i_cfg_wr_en) begin
            r_tpq <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_cmd  <= i_evt.command;
            r_ch   <= i_evt.channel;
            r_note <= i_evt.note_number;
            r_vel  <= i_evt.velocity;
            r_tick <= i_evt.event_tick[TICK_WIDTH-1:0];
        end
    end

    // slot state memory: count and head per slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            slot_mem[r_clr_addr] <= '0;
        end else if (i_cmd.push_wr) begin
            slot_mem[slot_cur] <= {cnt + CNT_W'(1), head};
        end else if (i_cmd.pop_load) begin
            slot_mem[slot_cur] <= {cnt - CNT_W'(1), head_nxt};
        end
        if (i_cmd.cap_item) begin
            r_slot_q <= slot_mem[slot_in];
        end else if (i_cmd.pop_load) begin
            r_slot_q <= {cnt - CNT_W'(1), head_nxt};
        end
    end

    // pending start memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            pend_mem[pend_waddr] <= {r_tick, r_vel};
        end
        if (i_cmd.pend_rd) begin
            r_pend_q <= pend_mem[pend_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.drop_load || i_cmd.pop_load) begin
            r_out_valid <= 1'b1;
        end else if (i_note_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drop_load) begin
            r_out.kind             <= KIND_DROP;
            r_out.start_tick       <= TICK_P_W'(r_tick);
            r_out.end_tick         <= '0;
            r_out.out_channel      <= r_ch;
            r_out.out_note         <= r_note;
            r_out.on_velocity      <= r_vel;
            r_out.release_velocity <= '0;
            r_out.last             <= 1'b1;
        end else if (i_cmd.pop_load) begin
            r_out.kind             <= KIND_NOTE;
            r_out.start_tick       <= TICK_P_W'(pend_tick);
            r_out.end_tick         <= TICK_P_W'(is_flush ? flush_end : r_tick);
            r_out.out_channel      <= r_ch;
            r_out.out_note         <= r_note;
            r_out.on_velocity      <= pend_vel;
            r_out.release_velocity <= (r_cmd == CMD_NOTE_OFF) ? r_vel : RELEASE_DEFAULT;
            r_out.last             <= !is_flush || (cnt == CNT_W'(1));
        end
    end

    assign o_note       = r_out;
    assign o_note_valid = r_out_valid;

    assign o_sts.clear_done = &r_clr_addr;
    assign o_sts.is_push    = (r_cmd == CMD_NOTE_ON) && (r_vel != '0);
    assign o_sts.is_pop     = ((r_cmd == CMD_NOTE_ON) && (r_vel == '0))
                              || (r_cmd == CMD_NOTE_OFF);
    assign o_sts.is_flush   = is_flush;
    assign o_sts.slot_empty = (cnt == '0);
    assign o_sts.slot_full  = (cnt >= CNT_W'(FIFO_DEPTH));
    assign o_sts.last_pop   = (cnt == CNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_note_ready;

endmodule

// File: hdl/mnp_ctrl.sv
// mnp_ctrl: sequencing of slot clear, push, drop and pop/flush for the note pairing unit
// depends on mnp_pkg
`timescale 1ns / 1ps

module mnp_ctrl
    import mnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_evt_valid,
    output logic       o_evt_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_DECODE = 2'd2;
    localparam logic [1:0] S_POP    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_evt_valid) begin
                    o_cmd.cap_item = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_push) begin
                    if (!i_sts.slot_full) begin
                        o_cmd.push_wr = 1'b1;
                        n_state       = S_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.drop_load = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.is_pop || i_sts.is_flush) begin
                    if (i_sts.slot_empty) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pend_rd = 1'b1;
                        n_state       = S_POP;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.pop_load = 1'b1;
                    if (i_sts.is_flush && !i_sts.last_pop) begin
                        o_cmd.pend_rd = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_evt_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push_wr |-> !i_sts.slot_full)
        else $error("push into a full slot");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_evt_ready)
        else $error("word accepted during slot clear");

    a_flush_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pop_load && o_cmd.pend_rd) |=> (r_state == S_POP))
        else $error("flush left pop loop with orphans remaining");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_load |-> !i_sts.slot_empty)
        else $error("pop from an empty slot");
`endif

endmodule

// File: sim/tb.sv
// tb: self-checking testbench of midi_note_on_off_pairing_unit with a note pairing scoreboard
// depends on mnp_pkg, mnp_ifs (mnp_evt_if, mnp_note_if) and the unit's rtl
`timescale 1ns / 1ps

import mnp_pkg::*;

localparam int               SLOT_DEPTH   = 4;
localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

// keeps a copy of the slot fifos and the quarter-note setting, works out the notes that
// each accepted event word must produce and matches them against the result words
class note_pairing_scoreboard;
    bit [31:0]   start_ticks [SLOT_NUM][SLOT_DEPTH];
    bit [6:0]    start_vels  [SLOT_NUM][SLOT_DEPTH];
    int unsigned fill [SLOT_NUM];
    int unsigned head [SLOT_NUM];
    bit [14:0]   tpq;
    t_note       awaited_notes[$];
    int          errors;
    int          cmd_seen [4];
    int          results_checked;
    int          drops;
    int          flushed;
    int          saturated;

    function new();
        tpq = TPQ_RESET;
        foreach (fill[i]) begin
            fill[i] = 0;
            head[i] = 0;
        end
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        errors = 0;
        results_checked = 0;
        drops = 0;
        flushed = 0;
        saturated = 0;
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // appends one note to the tail of the awaited list
    function void add_awaited(t_note r);
        awaited_notes = {awaited_notes, r};
    endfunction

    function void pop_start(int unsigned slot, output bit [31:0] st, output bit [6:0] sv);
        st = start_ticks[slot][head[slot]];
        sv = start_vels[slot][head[slot]];
        head[slot] = (head[slot] + 1) % SLOT_DEPTH;
        fill[slot]--;
    endfunction

    function void note_event(t_evt e);
        int unsigned slot;
        int unsigned pos;
        bit [32:0]   reach;
        bit [31:0]   close_at;
        bit [31:0]   st;
        bit [6:0]    sv;
        t_note       r;
        slot = 32'({e.channel, e.note_number});
        cmd_seen[e.command]++;
        r = '0;
        r.out_channel = e.channel;
        r.out_note = e.note_number;
        if (e.command == CMD_NOTE_ON && e.velocity != 0) begin
            if (fill[slot] >= SLOT_DEPTH) begin
                r.kind = KIND_DROP;
                r.start_tick = e.event_tick;
                r.on_velocity = e.velocity;
                r.last = 1'b1;
                add_awaited(r);
                drops++;
            end else begin
                pos = (head[slot] + fill[slot]) % SLOT_DEPTH;
                start_ticks[slot][pos] = e.event_tick;
                start_vels[slot][pos] = e.velocity;
                fill[slot]++;
            end
        end else if (e.command == CMD_NOTE_ON || e.command == CMD_NOTE_OFF) begin
            if (fill[slot] != 0) begin
                pop_start(slot, st, sv);
                r.kind = KIND_NOTE;
                r.start_tick = st;
                r.end_tick = e.event_tick;
                r.on_velocity = sv;
                r.release_velocity = (e.command == CMD_NOTE_ON) ? RELEASE_DEFAULT : e.velocity;
                r.last = 1'b1;
                add_awaited(r);
            end
        end else if (e.command == CMD_FLUSH) begin
            while (fill[slot] != 0) begin
                pop_start(slot, st, sv);
                reach = {1'b0, st} + 33'(tpq >> 2);
                if (reach > 33'h0_FFFF_FFFF) begin
                    reach = 33'h0_FFFF_FFFF;
                    saturated++;
                end
                close_at = reach[31:0];
                if (e.event_tick > close_at) close_at = e.event_tick;
                r.kind = KIND_NOTE;
                r.start_tick = st;
                r.end_tick = close_at;
                r.on_velocity = sv;
                r.release_velocity = RELEASE_DEFAULT;
                r.last = (fill[slot] == 0);
                add_awaited(r);
                flushed++;
            end
        end
    endfunction

    task check_field(string field, bit [31:0] got, bit [31:0] want);
        if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    task check_note(t_note got);
        t_note want;
        if (awaited_notes.size() == 0) begin
            report($sformatf("result with no note pending: kind %0d ch %0d note %0d",
                             got.kind, got.out_channel, got.out_note));
            return;
        end
        want = awaited_notes.pop_front();
        results_checked++;
        check_field("kind", got.kind, want.kind);
        check_field("start_tick", got.start_tick, want.start_tick);
        check_field("end_tick", got.end_tick, want.end_tick);
        check_field("out_channel", got.out_channel, want.out_channel);
        check_field("out_note", got.out_note, want.out_note);
        check_field("on_velocity", got.on_velocity, want.on_velocity);
        check_field("release_velocity", got.release_velocity, want.release_velocity);
        check_field("last", got.last, want.last);
    endtask
endclass

module tb;

    localparam int LONG_HOLD   = 300;
    // longest correct quiet stretch is the clearing pass after reset
    localparam int WATCH_LIMIT = 20000;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 87;
    localparam int SETTLE      = 16;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [TPQ_W-1:0] cfg_wr_data;

    mnp_evt_if  evt_if();
    mnp_note_if note_if();

    note_pairing_scoreboard sb = new();

    // random idling on both sides until the last phase
    bit          idle_on;
    int          hold_requests;
    int          holds_done;
    int          quiet_cycles;
    int          tpq_writes;
    logic [31:0] song_tick;
    logic [3:0]  hot_ch [6];
    logic [6:0]  hot_note [6];
    bit [14:0]   tpq_plan [PHASES];
    t_evt        seen_evt;
    t_note       seen_note;

    midi_note_on_off_pairing_unit DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_evt        (evt_if),
        .o_note       (note_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitors: results are checked before the event word of the same edge is noted,
    // which cannot matter since no event produces a result on its own edge
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (note_if.valid === 1'b1 && note_if.ready === 1'b1) begin
                seen_note.kind = note_if.kind;
                seen_note.start_tick = note_if.start_tick;
                seen_note.end_tick = note_if.end_tick;
                seen_note.out_channel = note_if.out_channel;
                seen_note.out_note = note_if.out_note;
                seen_note.on_velocity = note_if.on_velocity;
                seen_note.release_velocity = note_if.release_velocity;
                seen_note.last = note_if.last;
                sb.check_note(seen_note);
            end
            if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
                seen_evt.command = evt_if.command;
                seen_evt.channel = evt_if.channel;
                seen_evt.note_number = evt_if.note_number;
                seen_evt.velocity = evt_if.velocity;
                seen_evt.event_tick = evt_if.event_tick;
                sb.note_event(seen_evt);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if (rst_n !== 1'b1) begin
            quiet_cycles = 0;
        end else if ((evt_if.valid === 1'b1 && evt_if.ready === 1'b1) ||
                     (note_if.valid === 1'b1 && note_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("timeout after %0d cycles with no word accepted", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold so the unit backs up into its input
    initial begin
        note_if.ready <= 1'b0;
        holds_done = 0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (holds_done < hold_requests) begin
                note_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                note_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                note_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // offer one event word and hold it until taken; valid stays up for a back-to-back word
    task automatic send_word(input t_evt w);
        evt_if.valid <= 1'b1;
        evt_if.command <= w.command;
        evt_if.channel <= w.channel;
        evt_if.note_number <= w.note_number;
        evt_if.velocity <= w.velocity;
        evt_if.event_tick <= w.event_tick;
        @(posedge clk);
        while (evt_if.ready !== 1'b1) @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic play(input logic [1:0] cmd, input logic [3:0] ch, input logic [6:0] nt,
                        input logic [6:0] vel, input logic [31:0] tick);
        t_evt w;
        w.command = cmd;
        w.channel = ch;
        w.note_number = nt;
        w.velocity = vel;
        w.event_tick = tick;
        send_word(w);
    endtask

    // idle the input, let every pending note come out, then give no-result words time
    task automatic settle();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_notes.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tpq(input logic [TPQ_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.tpq = value;
        tpq_writes++;
    endtask

    // mostly small steps forward in song time, some jumps and some ticks near the top
    function automatic logic [31:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) song_tick = song_tick + $urandom_range(0, 2000);
        else if (r < 85) song_tick = $urandom;
        else song_tick = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        return song_tick;
    endfunction

    // a handful of busy slots so fifos fill, drain and overflow; the rest anywhere
    function automatic t_evt random_word();
        t_evt w;
        int   r;
        int   k;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, 5);
            w.channel = hot_ch[k];
            w.note_number = hot_note[k];
        end else begin
            w.channel = 4'($urandom_range(0, 15));
            w.note_number = 7'($urandom_range(0, 127));
        end
        w.velocity = 7'($urandom_range(1, 127));
        w.event_tick = pick_tick();
        if (r < 45) begin
            w.command = CMD_NOTE_ON;
        end else if (r < 55) begin
            w.command = CMD_NOTE_ON;
            w.velocity = '0;
        end else if (r < 82) begin
            w.command = CMD_NOTE_OFF;
            w.velocity = 7'($urandom_range(0, 127));
        end else if (r < 96) begin
            w.command = CMD_FLUSH;
            w.velocity = 7'($urandom_range(0, 127));
        end else begin
            w.command = CMD_RESERVED;
        end
        return w;
    endfunction

    initial begin
        int   phase;
        int   counted;
        t_evt w;

        evt_if.valid <= 1'b0;
        evt_if.command <= CMD_NOTE_ON;
        evt_if.channel <= '0;
        evt_if.note_number <= '0;
        evt_if.velocity <= '0;
        evt_if.event_tick <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        rst_n <= 1'b0;
        idle_on = 1'b1;
        hold_requests = 0;
        tpq_writes = 0;
        song_tick = '0;
        tpq_plan = '{15'd0, 15'd1, TPQ_RESET, 15'd32767, 15'd0};
        tpq_plan[PHASES-1] = 15'($urandom_range(2, 32766));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // largest setting while the clearing pass runs
        write_tpq(15'd32767);

        // directed: field extremes, explicit and implicit note-off
        play(CMD_NOTE_ON, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
        play(CMD_NOTE_OFF, 4'd15, 7'd127, 7'd127, 32'h0000_0000);
        play(CMD_NOTE_ON, 4'd0, 7'd0, 7'd1, 32'h0000_0000);
        play(CMD_NOTE_ON, 4'd0, 7'd0, 7'd0, 32'd100);
        // note-off on an empty slot produces nothing
        play(CMD_NOTE_OFF, 4'd0, 7'd0, 7'd0, 32'd5);
        // fill one fifo, then overflow it
        play(CMD_NOTE_ON, 4'd5, 7'd60, 7'd10, 32'd1000);
        play(CMD_NOTE_ON, 4'd5, 7'd60, 7'd20, 32'd2000);
        play(CMD_NOTE_ON, 4'd5, 7'd60, 7'd30, 32'd3000);
        play(CMD_NOTE_ON, 4'd5, 7'd60, 7'd40, 32'hFFFF_FFF0);
        play(CMD_NOTE_ON, 4'd5, 7'd60, 7'd50, 32'd3500);
        play(CMD_NOTE_OFF, 4'd5, 7'd60, 7'd3, 32'd4000);
        // unused command code is ignored
        play(CMD_RESERVED, 4'd5, 7'd60, 7'd99, 32'd4100);
        // flush: minimum length wins, last orphan saturates at the top of tick range
        play(CMD_FLUSH, 4'd5, 7'd60, 7'd0, 32'd2500);
        // flush of a slot with nothing pending
        play(CMD_FLUSH, 4'd5, 7'd60, 7'd0, 32'd9000);
        // flush where the track end wins
        play(CMD_NOTE_ON, 4'd15, 7'd127, 7'd127, 32'd100);
        play(CMD_NOTE_ON, 4'd15, 7'd127, 7'd5, 32'd200);
        play(CMD_FLUSH, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
        play(CMD_NOTE_ON, 4'd0, 7'd0, 7'd64, 32'h7FFF_FFFF);
        play(CMD_FLUSH, 4'd0, 7'd0, 7'd0, 32'd1);
        play(CMD_NOTE_ON, 4'd10, 7'd85, 7'd85, 32'hAAAA_AAAA);
        play(CMD_NOTE_OFF, 4'd10, 7'd85, 7'd42, 32'h5555_5555);
        // full fifo closed by one flush, four results from one word
        play(CMD_NOTE_ON, 4'd3, 7'd64, 7'd1, 32'd10);
        play(CMD_NOTE_ON, 4'd3, 7'd64, 7'd2, 32'd20);
        play(CMD_NOTE_ON, 4'd3, 7'd64, 7'd3, 32'd30);
        play(CMD_NOTE_ON, 4'd3, 7'd64, 7'd4, 32'd40);
        play(CMD_FLUSH, 4'd3, 7'd64, 7'd0, 32'd15);

        // random phases, one quarter-note setting each, extremes and zero among them
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            write_tpq(tpq_plan[phase]);
            for (int k = 0; k < 6; k++) begin
                hot_ch[k] = 4'($urandom_range(0, 15));
                hot_note[k] = 7'($urandom_range(0, 127));
            end
            if (phase == 1) hold_requests++;
            if (phase == PHASES - 1) idle_on = 1'b0;
            counted = 0;
            while (counted < PHASE_WORDS) begin
                w = random_word();
                send_word(w);
                if (w.command != CMD_RESERVED) counted++;
            end
        end

        settle();
        if (sb.awaited_notes.size() != 0)
            sb.report($sformatf("%0d notes never came out", sb.awaited_notes.size()));

        $display("covered %0d note-on, %0d note-off, %0d flush and %0d unused-code words",
                 sb.cmd_seen[CMD_NOTE_ON], sb.cmd_seen[CMD_NOTE_OFF],
                 sb.cmd_seen[CMD_FLUSH], sb.cmd_seen[CMD_RESERVED]);
        $display("checked %0d notes: %0d drops, %0d flushed (%0d saturated), %0d tpq writes",
                 sb.results_checked, sb.drops, sb.flushed, sb.saturated, tpq_writes);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
